@@ src/sample_player_mixer_with_fades_unit_assert.svh @@
// Assertion macros used by the checker of the sample player.
`ifndef SAMPLE_PLAYER_MIXER_WITH_FADES_UNIT_ASSERT_SVH
`define SAMPLE_PLAYER_MIXER_WITH_FADES_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/spm_pkg.sv @@
// Shared types and constants of the sample player mixer.
package spm_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 17;
  localparam int unsigned LenW    = 15;
  localparam logic [GainW-1:0] GainOne = 17'd65536;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_LENGTH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LOOP_MASK   = 2'd0,
    REG_FADE_LENGTH = 2'd1,
    REG_FADE_STEP   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VISIT,
    ST_READ,
    ST_MIX,
    ST_OUT
  } state_t;

  // Per-slot control for a cell.
  typedef struct packed {
    logic             shift;   // rotate all cells by one
    logic             set_len; // write length into the head cell
    logic [LenW-1:0]  len;
  } cell_ctl_t;

  // Slot state carried around the ring.
  typedef struct packed {
    logic             playing;
    logic             latched;
    logic             fading;
    logic             pending;
    logic [LenW-1:0]  length;
    logic [LenW-1:0]  pos;
    logic [GainW-1:0] gain;
  } slot_t;

  function automatic logic signed [SampleW-1:0] clamp16(input logic signed [SampleW+1:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 18'sd32767) r = 16'sh7FFF;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[SampleW-1:0];
    return r;
  endfunction
endpackage

@@ src/sample_player_mixer_with_fades_unit.sv @@
// Top level of the multi-slot stereo sample player and mixer.
// Channels: in_ (slave) takes one command per transfer; out_ (master) gives
// one result per command: the mixed frame for a tick, zeros otherwise, and
// the playing mask after the command. The user must write cfg_ loop_mask (0),
// fade_length (1) and fade_step (2) while the block is idle (not enforced).
// Slot state lives in a ring of cells that rotates by one each step; the
// head slot is updated, its sample read from the store and mixed.
// A tick visits every slot in turn through VISIT, READ and MIX, as the
// single sample store read port and the product are both registered.
// Trigger and length commands on a present slot rotate the ring through
// VISIT and MIX per slot; writes and other commands go straight to OUT.
// in_tready is high in IDLE only; the result is held in an output register,
// so a stalled receiver holds the block in OUT.
// Reset clears all slot state and sets the cfg_ registers to their defaults;
// sample memory content is undefined until written.
module sample_player_mixer_with_fades_unit import spm_pkg::*; #(
  parameter int unsigned SLOT_COUNT      = 8,
  parameter int unsigned FRAMES_PER_SLOT = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], slot[4:2], frame_address[18:5], sample_left[34:19],
  // sample_right[50:35], slot_frames[65:51], zero fill
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mix_left[15:0], mix_right[31:16], playing_mask[39:32]
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned AW = $clog2(FRAMES_PER_SLOT);
  localparam int unsigned DEPTH = SLOT_COUNT * FRAMES_PER_SLOT;

  logic [7:0]  loop_mask_r;
  logic [15:0] fade_len_r;
  logic [16:0] fade_step_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mask_r <= '0;
      fade_len_r <= 16'd2205;
      fade_step_r <= 17'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOP_MASK:   loop_mask_r <= cfg_wdata[7:0];
        REG_FADE_LENGTH: fade_len_r <= cfg_wdata[15:0];
        REG_FADE_STEP:   fade_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  logic [2:0] slot_f;
  logic [13:0] addr_f;
  logic [15:0] sl_f, sr_f;
  logic [14:0] len_f;
  assign cmd    = cmd_t'(in_tdata[1:0]);
  assign slot_f = in_tdata[4:2];
  assign addr_f = in_tdata[18:5];
  assign sl_f   = in_tdata[34:19];
  assign sr_f   = in_tdata[50:35];
  assign len_f  = in_tdata[65:51];

  state_t st_r, st_nxt;
  logic [SW:0] cnt_r, cnt_nxt;
  logic [SW-1:0] head_r, head_nxt;  // slot index at the head cell
  logic acc;
  assign acc = in_tvalid && in_tready;

  logic cmd_r;           // latched: command is a tick
  logic is_trig_r, is_len_r;
  logic [SW-1:0] tslot_r;
  logic [LenW-1:0] tlen_r;
  logic valid_slot;
  assign valid_slot = ({1'b0, slot_f} < 4'(SLOT_COUNT));

  // ring of cells
  slot_t ring [SLOT_COUNT];
  slot_t head_in, head_upd;
  logic shift;
  logic active;
  logic [AW-1:0] rd_pos;
  logic [GainW-1:0] step_sat;
  logic is_loop;
  slot_t feed;
  logic cmd_slot_hit;

  assign step_sat = (fade_step_r == '0) ? 17'd1 :
                    (fade_step_r > GainOne) ? GainOne : fade_step_r;
  assign is_loop = loop_mask_r[3'(head_r)];

  always_comb begin
    head_in = ring[0];
    cmd_slot_hit = (head_r == tslot_r);
    if (is_trig_r && cmd_slot_hit) head_in.pending = 1'b1;
    if (is_len_r && cmd_slot_hit) begin
      head_in.playing = 1'b0; head_in.latched = 1'b0; head_in.fading = 1'b0;
      head_in.pos = '0; head_in.gain = '0; head_in.length = tlen_r;
    end
  end

  spm_slot_logic #(.AW(AW)) u_logic (
    .s_in(ring[0]), .is_loop(is_loop), .step(step_sat), .fade_len(fade_len_r),
    .s_out(head_upd), .active(active), .rd_pos(rd_pos)
  );

  // cell 0 is head; rotation moves cell k+1 into k and head to the tail
  slot_t upd_r;
  logic  act_r;
  assign feed = cmd_r ? upd_r : head_in;
  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      slot_t prv;
      if (g == SLOT_COUNT - 1) begin : g_tail
        assign prv = feed;
      end else begin : g_mid
        assign prv = ring[g+1];
      end
      spm_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .prev(prv), .cur(ring[g]));
    end
  endgenerate

  // sample memory
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_r;
  logic [SW+AW-1:0] wa, ra;
  assign wa = {slot_f[SW-1:0], addr_f[AW-1:0]};
  assign ra = {head_r, rd_pos};
  always_ff @(posedge clk) begin
    if (acc && cmd == CMD_WRITE && valid_slot && {1'b0, addr_f} < 15'(FRAMES_PER_SLOT))
      mem[wa] <= {sl_f, sr_f};
    if (st_r == ST_VISIT) rd_r <= mem[ra];
  end

  // mixing
  logic signed [15:0] ml_r, mr_r, ml_nxt, mr_nxt;
  logic signed [33:0] pl_r, pr_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_READ) begin
      pl_r <= $signed(rd_r[31:16]) * $signed({1'b0, upd_r.gain});
      pr_r <= $signed(rd_r[15:0])  * $signed({1'b0, upd_r.gain});
    end
  end
  logic signed [33:0] ql, qr;
  always_comb begin
    ql = (pl_r < 0) ? (pl_r + 34'sd65535) >>> 16 : pl_r >>> 16;
    qr = (pr_r < 0) ? (pr_r + 34'sd65535) >>> 16 : pr_r >>> 16;
    ml_nxt = clamp16(18'(ml_r) + 18'(ql[17:0]));
    mr_nxt = clamp16(18'(mr_r) + 18'(qr[17:0]));
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    head_nxt = head_r;
    case (st_r)
      ST_IDLE:  if (acc) st_nxt = (cmd == CMD_TICK) ? ST_VISIT :
                         ((cmd == CMD_LENGTH || cmd == CMD_TRIGGER) && valid_slot) ?
                         ST_VISIT : ST_OUT;
      ST_VISIT: st_nxt = cmd_r ? ST_READ : ST_MIX;
      ST_READ:  st_nxt = ST_MIX;
      ST_MIX: begin
        head_nxt = (head_r == SW'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        st_nxt = (cnt_r == (SW+1)'(SLOT_COUNT - 1)) ? ST_OUT : ST_VISIT;
      end
      ST_OUT:   if (out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_IDLE) cnt_nxt = '0;
  end

  always_comb begin
    in_tready = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_OUT);
    shift = (st_r == ST_MIX);
  end

  logic [7:0] pm;
  always_comb begin
    pm = '0;
    for (int k = 0; k < SLOT_COUNT; k++) pm[k] = ring[k].playing;
  end
  assign out_tdata = {pm, mr_r, ml_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      head_r <= '0;
      cmd_r <= 1'b0;
      is_trig_r <= 1'b0;
      is_len_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      head_r <= head_nxt;
      if (acc) begin
        cmd_r <= (cmd == CMD_TICK);
        is_trig_r <= (cmd == CMD_TRIGGER) && valid_slot;
        is_len_r <= (cmd == CMD_LENGTH) && valid_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tslot_r <= slot_f[SW-1:0];
      tlen_r <= (len_f > 15'(FRAMES_PER_SLOT)) ? 15'(FRAMES_PER_SLOT) : len_f;
      ml_r <= '0;
      mr_r <= '0;
    end else if (st_r == ST_MIX && cmd_r && act_r) begin
      ml_r <= ml_nxt;
      mr_r <= mr_nxt;
    end
    if (st_r == ST_VISIT) begin
      upd_r <= head_upd;
      act_r <= active;
    end
  end
endmodule

@@ src/spm_cell.sv @@
// One slot cell of the rotating ring; takes the previous cell's slot state on shift and holds it otherwise.
module spm_cell import spm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift,
  input  slot_t     prev,
  output slot_t     cur
);
  slot_t st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (shift) begin
      st_r <= prev;
    end
  end
  assign cur = st_r;
endmodule

@@ src/spm_slot_logic.sv @@
// Trigger, end-of-sample and gain ramp rules applied to the head slot.
module spm_slot_logic import spm_pkg::*; #(
  parameter int unsigned AW = 14
) (
  input  slot_t            s_in,
  input  logic             is_loop,
  input  logic [GainW-1:0] step,
  input  logic [15:0]      fade_len,
  output slot_t            s_out,
  output logic             active,
  output logic [AW-1:0]    rd_pos
);
  slot_t a;
  slot_t b;
  logic [GainW:0] up;
  logic signed [GainW+1:0] dn;
  logic signed [LenW+1:0] thr;
  always_comb begin
    a = s_in;
    b = s_in;
    active = 1'b0;
    up = '0;
    dn = '0;
    thr = '0;
    if (a.pending) begin
      a.pending = 1'b0;
      if (a.playing && is_loop && a.latched) begin
        a.fading = 1'b1;
        a.latched = 1'b0;
      end else if (!a.playing || !is_loop) begin
        if (a.length != '0) begin
          a.playing = 1'b1;
          a.latched = is_loop;
          a.fading = 1'b0;
          a.pos = '0;
          a.gain = '0;
        end
      end
    end
    b = a;
    if (a.playing) begin
      if (a.pos >= a.length && !(is_loop && a.latched)) begin
        b.playing = 1'b0; b.latched = 1'b0; b.fading = 1'b0; b.pos = '0; b.gain = '0;
      end else begin
        if (a.pos >= a.length) b.pos = '0;
        if (!b.fading) begin
          up = {1'b0, b.gain} + {1'b0, step};
          if (b.gain < GainOne) b.gain = (up > {1'b0, GainOne}) ? GainOne : up[GainW-1:0];
          active = 1'b1;
        end else begin
          dn = $signed({2'b0, b.gain}) - $signed({2'b0, step});
          if (dn <= 0) begin
            b.playing = 1'b0; b.latched = 1'b0; b.fading = 1'b0;
            b.pos = '0; b.gain = '0;
          end else begin
            b.gain = dn[GainW-1:0];
            active = 1'b1;
          end
        end
        if (active && !is_loop && !b.fading) begin
          thr = $signed({2'b0, b.length}) - $signed({2'b0, fade_len[LenW-1:0]});
          if (fade_len[15] || $signed({2'b0, b.pos}) >= thr) b.fading = 1'b1;
        end
      end
    end
    rd_pos = b.pos[AW-1:0];
    // advance past the frame just read
    if (active) b.pos = b.pos + 1'b1;
    s_out = b;
  end
endmodule

@@ src/spm_checker.sv @@
// Port-level checker for the sample player, bound to the top level.
`include "sample_player_mixer_with_fades_unit_assert.svh"
module spm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `SPM_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken during result")
  `SPM_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `SPM_ASSERT_NEXT(a_zero_mix, clk, rst_n, in_tvalid && in_tready && in_tdata[1:0] != 2'd0, out_tdata[31:0] == 32'd0, "non-tick mix not zero")
  `SPM_ASSERT_NEXT(a_ready_back, clk, rst_n, out_tvalid && out_tready, in_tready, "not idle after result")
endmodule

bind sample_player_mixer_with_fades_unit spm_checker u_spm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
